>>> sv/c_subset_lexer_defines.svh
// Assertion macros for the C subset lexer.
// Used by the top level; relies on aclk and aresetn in the including scope.
`ifndef C_SUBSET_LEXER_DEFINES_SVH
`define C_SUBSET_LEXER_DEFINES_SVH

// Same-cycle implication, disabled in reset.
`define CSL_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("c_subset_lexer: check failed");

// Next-cycle implication, disabled in reset.
`define CSL_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("c_subset_lexer: check failed");

`endif

>>> sv/csl_pkg.sv
// Shared types and constants for the C subset lexer.
// No dependencies; imported by every module of the block.
`default_nettype none

package csl_pkg;

    localparam int QUEUE_DEPTH = 4;

    typedef enum logic [1:0] {
        MODE_IDLE   = 2'd0,
        MODE_IDENT  = 2'd1,
        MODE_NUMBER = 2'd2,
        MODE_OPER   = 2'd3
    } scan_mode_t;

    typedef enum logic [4:0] {
        TK_INVALID = 5'd0,
        TK_LBRACE  = 5'd1,
        TK_RBRACE  = 5'd2,
        TK_LPAREN  = 5'd3,
        TK_RPAREN  = 5'd4,
        TK_SEMI    = 5'd5,
        TK_INT     = 5'd6,
        TK_RETURN  = 5'd7,
        TK_IDENT   = 5'd8,
        TK_LITERAL = 5'd9,
        TK_NOT     = 5'd10,
        TK_TILDE   = 5'd11,
        TK_MINUS   = 5'd12,
        TK_PLUS    = 5'd13,
        TK_STAR    = 5'd14,
        TK_SLASH   = 5'd15,
        TK_PERCENT = 5'd16,
        TK_EQ      = 5'd17,
        TK_NE      = 5'd18,
        TK_LAND    = 5'd19,
        TK_LOR     = 5'd20,
        TK_LT      = 5'd21,
        TK_LE      = 5'd22,
        TK_GT      = 5'd23,
        TK_GE      = 5'd24,
        TK_ASSIGN  = 5'd25
    } tok_kind_t;

    typedef struct packed {
        tok_kind_t   kind;
        logic [31:0] value;
        logic [7:0]  length;
        logic [31:0] start;
        logic [31:0] line;
    } token_t;

    // One accepted byte gives at most two tokens; an entry holds one or two of them.
    typedef struct packed {
        token_t tok0;
        token_t tok1;
        logic   two;
    } entry_t;

    typedef struct packed {
        scan_mode_t  mode;
        logic [31:0] position;
    } front_status_t;

endpackage

`default_nettype wire

>>> sv/csl_queue.sv
// Short token queue between the lexer front end and the output stage.
// Depends on csl_pkg for the entry type.
`default_nettype none

module csl_queue #(
    parameter int DEPTH = 4
) (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            push,
    input  wire csl_pkg::entry_t push_entry,
    input  wire logic            pop,
    output csl_pkg::entry_t      head,
    output logic                 full,
    output logic                 empty
);
    import csl_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    entry_t             slot_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg, count_next;

    function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] p);
        bump = (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    assign full  = (count_reg == CNT_W'(DEPTH));
    assign empty = (count_reg == '0);
    assign head  = slot_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push ? bump(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = pop ? bump(rd_ptr_reg) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

`default_nettype wire

>>> sv/csl_front.sv
// Lexer front end: accepts source bytes, keeps the scan state and forms tokens.
// Depends on csl_pkg; feeds csl_queue.
`default_nettype none

module csl_front #(
    parameter int MAX_TOKEN_LEN = 255
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire logic [7:0]         s_char_in,
    input  wire logic               s_flush,
    input  wire logic               cfg_write,
    input  wire logic [31:0]        cfg_data,
    input  wire logic               q_full,
    output logic                    push,
    output csl_pkg::entry_t         push_entry,
    output csl_pkg::front_status_t  status
);
    import csl_pkg::*;

    localparam int LEN_W = $clog2(MAX_TOKEN_LEN + 1);
    localparam int EXT_W = (LEN_W > 8) ? LEN_W : 8;

    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SP    = 8'h20;
    localparam logic [7:0] CH_BANG  = 8'h21;
    localparam logic [7:0] CH_PCT   = 8'h25;
    localparam logic [7:0] CH_AMP   = 8'h26;
    localparam logic [7:0] CH_LPAR  = 8'h28;
    localparam logic [7:0] CH_RPAR  = 8'h29;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_SEMI  = 8'h3B;
    localparam logic [7:0] CH_LT    = 8'h3C;
    localparam logic [7:0] CH_EQ    = 8'h3D;
    localparam logic [7:0] CH_GT    = 8'h3E;
    localparam logic [7:0] CH_UPA   = 8'h41;
    localparam logic [7:0] CH_UPZ   = 8'h5A;
    localparam logic [7:0] CH_UNDER = 8'h5F;
    localparam logic [7:0] CH_LOA   = 8'h61;
    localparam logic [7:0] CH_LOZ   = 8'h7A;
    localparam logic [7:0] CH_LBRC  = 8'h7B;
    localparam logic [7:0] CH_BAR   = 8'h7C;
    localparam logic [7:0] CH_RBRC  = 8'h7D;
    localparam logic [7:0] CH_TILDE = 8'h7E;
    localparam logic [7:0] CH_I     = 8'h69;
    localparam logic [7:0] CH_N     = 8'h6E;
    localparam logic [7:0] CH_T     = 8'h74;
    localparam logic [7:0] CH_R     = 8'h72;
    localparam logic [7:0] CH_E     = 8'h65;
    localparam logic [7:0] CH_U     = 8'h75;

    function automatic logic [7:0] kw_int_char(input logic [2:0] p);
        case (p)
            3'd0:    kw_int_char = CH_I;
            3'd1:    kw_int_char = CH_N;
            default: kw_int_char = CH_T;
        endcase
    endfunction

    function automatic logic [7:0] kw_ret_char(input logic [2:0] p);
        case (p)
            3'd0:    kw_ret_char = CH_R;
            3'd1:    kw_ret_char = CH_E;
            3'd2:    kw_ret_char = CH_T;
            3'd3:    kw_ret_char = CH_U;
            3'd4:    kw_ret_char = CH_R;
            default: kw_ret_char = CH_N;
        endcase
    endfunction

    function automatic tok_kind_t oper_kind(input logic [7:0] op, input logic two);
        case (op)
            CH_BANG: oper_kind = two ? TK_NE : TK_NOT;
            CH_EQ:   oper_kind = two ? TK_EQ : TK_ASSIGN;
            CH_LT:   oper_kind = two ? TK_LE : TK_LT;
            CH_GT:   oper_kind = two ? TK_GE : TK_GT;
            CH_AMP:  oper_kind = two ? TK_LAND : TK_INVALID;
            CH_BAR:  oper_kind = two ? TK_LOR : TK_INVALID;
            default: oper_kind = TK_INVALID;
        endcase
    endfunction

    function automatic tok_kind_t single_kind(input logic [7:0] c);
        case (c)
            CH_LBRC:  single_kind = TK_LBRACE;
            CH_RBRC:  single_kind = TK_RBRACE;
            CH_LPAR:  single_kind = TK_LPAREN;
            CH_RPAR:  single_kind = TK_RPAREN;
            CH_SEMI:  single_kind = TK_SEMI;
            CH_TILDE: single_kind = TK_TILDE;
            CH_MINUS: single_kind = TK_MINUS;
            CH_PLUS:  single_kind = TK_PLUS;
            CH_STAR:  single_kind = TK_STAR;
            CH_SLASH: single_kind = TK_SLASH;
            CH_PCT:   single_kind = TK_PERCENT;
            default:  single_kind = TK_INVALID;
        endcase
    endfunction

    scan_mode_t        mode_reg, mode_next;
    logic [7:0]        op_reg, op_next;
    logic [31:0]       acc_reg, acc_next;
    logic [LEN_W-1:0]  len_reg, len_next;
    logic [31:0]       start_reg, start_next;
    logic [31:0]       tline_reg, tline_next;
    logic [31:0]       line_reg, line_next;
    logic [31:0]       pos_reg, pos_next;
    logic [1:0]        km_reg, km_next;
    logic [31:0]       first_line_reg;

    logic              accept;
    logic              is_letter, is_digit, is_space, is_op_start, completes;
    logic              pend_ok, single_ok;
    token_t            pend, single;
    logic [1:0]        n_tok;
    logic [EXT_W-1:0]  len_ext;
    logic [7:0]        len_sat;
    logic [LEN_W-1:0]  len_grow;
    logic [2:0]        kw_idx;

    assign s_ready = !q_full;
    assign accept  = s_valid && s_ready;
    assign status  = '{mode: mode_reg, position: pos_reg};

    assign is_letter   = ((s_char_in >= CH_LOA) && (s_char_in <= CH_LOZ)) ||
                         ((s_char_in >= CH_UPA) && (s_char_in <= CH_UPZ));
    assign is_digit    = (s_char_in >= CH_ZERO) && (s_char_in <= CH_NINE);
    assign is_space    = (s_char_in == CH_SP) || (s_char_in == CH_TAB) ||
                         (s_char_in == CH_CR) || (s_char_in == CH_LF);
    assign is_op_start = (s_char_in == CH_BANG) || (s_char_in == CH_EQ) ||
                         (s_char_in == CH_LT) || (s_char_in == CH_GT) ||
                         (s_char_in == CH_AMP) || (s_char_in == CH_BAR);
    assign completes   = ((op_reg == CH_AMP) || (op_reg == CH_BAR)) ?
                         (s_char_in == op_reg) : (s_char_in == CH_EQ);

    assign len_ext  = EXT_W'(len_reg);
    assign len_sat  = (len_ext > EXT_W'(255)) ? 8'hFF : len_ext[7:0];
    assign len_grow = (len_reg < LEN_W'(MAX_TOKEN_LEN)) ? len_reg + 1'b1 : len_reg;
    assign kw_idx   = len_reg[2:0];

    always_comb begin
        pend         = '0;
        pend.start   = start_reg;
        pend.line    = tline_reg;
        pend.length  = len_sat;
        pend.kind    = TK_INVALID;
        pend_ok      = 1'b1;
        unique case (mode_reg)
            MODE_IDENT: begin
                if (km_reg[0] && (len_reg == LEN_W'(3))) begin
                    pend.kind = TK_INT;
                end else if (km_reg[1] && (len_reg == LEN_W'(6))) begin
                    pend.kind = TK_RETURN;
                end else begin
                    pend.kind = TK_IDENT;
                end
            end
            MODE_NUMBER: begin
                pend.kind  = TK_LITERAL;
                pend.value = acc_reg;
            end
            MODE_OPER: begin
                pend.kind   = oper_kind(op_reg, 1'b0);
                pend.length = 8'd1;
            end
            default: begin
                pend_ok = 1'b0;
            end
        endcase

        single        = '0;
        single.kind   = single_kind(s_char_in);
        single.length = 8'd1;
        single.start  = pos_reg;
        single.line   = line_reg;
        single_ok     = 1'b0;

        mode_next  = mode_reg;
        op_next    = op_reg;
        acc_next   = acc_reg;
        len_next   = len_reg;
        start_next = start_reg;
        tline_next = tline_reg;
        line_next  = line_reg;
        pos_next   = pos_reg;
        km_next    = km_reg;
        n_tok      = 2'd0;
        push_entry = '0;

        if (accept) begin
            if (s_flush) begin
                push_entry.tok0 = pend;
                n_tok      = {1'b0, pend_ok};
                mode_next  = MODE_IDLE;
                op_next    = '0;
                acc_next   = '0;
                len_next   = '0;
                start_next = '0;
                tline_next = '0;
                km_next    = 2'b11;
                pos_next   = '0;
                line_next  = first_line_reg;
            end else begin
                pos_next = pos_reg + 1'b1;
                if ((mode_reg == MODE_IDENT) && (is_letter || is_digit ||
                                                 (s_char_in == CH_UNDER))) begin
                    if (!((len_reg < LEN_W'(3)) && (s_char_in == kw_int_char(kw_idx)))) begin
                        km_next[0] = 1'b0;
                    end
                    if (!((len_reg < LEN_W'(6)) && (s_char_in == kw_ret_char(kw_idx)))) begin
                        km_next[1] = 1'b0;
                    end
                    len_next = len_grow;
                end else if ((mode_reg == MODE_NUMBER) && is_digit) begin
                    acc_next = {acc_reg[28:0], 3'b000} + {acc_reg[30:0], 1'b0} +
                               {24'd0, s_char_in - CH_ZERO};
                    len_next = len_grow;
                end else if ((mode_reg == MODE_OPER) && completes) begin
                    push_entry.tok0        = pend;
                    push_entry.tok0.kind   = oper_kind(op_reg, 1'b1);
                    push_entry.tok0.length = 8'd2;
                    n_tok      = 2'd1;
                    mode_next  = MODE_IDLE;
                    op_next    = '0;
                    acc_next   = '0;
                    len_next   = '0;
                    start_next = '0;
                    tline_next = '0;
                    km_next    = 2'b11;
                end else begin
                    mode_next  = MODE_IDLE;
                    op_next    = '0;
                    acc_next   = '0;
                    len_next   = '0;
                    start_next = '0;
                    tline_next = '0;
                    km_next    = 2'b11;
                    if (is_space) begin
                        if (s_char_in == CH_LF) begin
                            line_next = line_reg + 1'b1;
                        end
                    end else if (is_letter || is_digit || is_op_start) begin
                        mode_next  = is_letter ? MODE_IDENT :
                                     (is_digit ? MODE_NUMBER : MODE_OPER);
                        start_next = pos_reg;
                        tline_next = line_reg;
                        len_next   = LEN_W'(1);
                        if (is_letter) begin
                            km_next = {s_char_in == CH_R, s_char_in == CH_I};
                        end
                        if (is_digit) begin
                            acc_next = {24'd0, s_char_in - CH_ZERO};
                        end
                        if (is_op_start) begin
                            op_next = s_char_in;
                        end
                    end else begin
                        single_ok = 1'b1;
                    end
                    if (pend_ok) begin
                        push_entry.tok0 = pend;
                        push_entry.tok1 = single;
                        n_tok = single_ok ? 2'd2 : 2'd1;
                    end else begin
                        push_entry.tok0 = single;
                        n_tok = {1'b0, single_ok};
                    end
                end
            end
        end

        push_entry.two = (n_tok == 2'd2);
        push = (n_tok != 2'd0);

        if (cfg_write && (pos_reg == '0)) begin
            line_next = cfg_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg       <= MODE_IDLE;
            op_reg         <= '0;
            acc_reg        <= '0;
            len_reg        <= '0;
            start_reg      <= '0;
            tline_reg      <= '0;
            line_reg       <= 32'd1;
            pos_reg        <= '0;
            km_reg         <= 2'b11;
            first_line_reg <= 32'd1;
        end else begin
            mode_reg  <= mode_next;
            op_reg    <= op_next;
            acc_reg   <= acc_next;
            len_reg   <= len_next;
            start_reg <= start_next;
            tline_reg <= tline_next;
            line_reg  <= line_next;
            pos_reg   <= pos_next;
            km_reg    <= km_next;
            if (cfg_write) begin
                first_line_reg <= cfg_data;
            end
        end
    end

endmodule

`default_nettype wire

>>> sv/csl_back.sv
// Lexer output stage: splits queued entries into single tokens and registers them.
// Depends on csl_pkg; drains csl_queue.
`default_nettype none

module csl_back (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire csl_pkg::entry_t head,
    input  wire logic            q_empty,
    output logic                 pop,
    output logic                 m_valid,
    input  wire logic            m_ready,
    output csl_pkg::token_t      m_token,
    output logic                 m_last
);
    import csl_pkg::*;

    logic   valid_reg, valid_next;
    logic   idx_reg, idx_next;
    token_t tok_reg;
    logic   last_reg;
    logic   load, last_now;

    assign m_valid  = valid_reg;
    assign m_token  = tok_reg;
    assign m_last   = last_reg;
    assign load     = (!valid_reg || m_ready) && !q_empty;
    assign last_now = !head.two || idx_reg;
    assign pop      = load && last_now;

    always_comb begin
        valid_next = valid_reg;
        idx_next   = idx_reg;
        if (load) begin
            valid_next = 1'b1;
            idx_next   = last_now ? 1'b0 : 1'b1;
        end else if (m_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            idx_reg   <= 1'b0;
        end else begin
            valid_reg <= valid_next;
            idx_reg   <= idx_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            tok_reg  <= idx_reg ? head.tok1 : head.tok0;
            last_reg <= last_now;
        end
    end

endmodule

`default_nettype wire

>>> sv/c_subset_lexer.sv
// C subset lexer: one byte per cycle in while s_ready, one token per cycle out while m_ready.
// The token that a byte ends is registered in the queue, then in the output register.
// Throughput: 1 byte per cycle while s_ready; a two-token byte uses the output stage twice.
// Reset (aresetn low, synchronous): scan idle, queue empty, line number and register 1.
// Depends on csl_pkg, csl_front, csl_queue, csl_back and c_subset_lexer_defines.svh.
`default_nettype none

`include "c_subset_lexer_defines.svh"

module c_subset_lexer #(
    parameter int MAX_TOKEN_LEN = 255
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [7:0]  s_char_in,
    input  wire logic        s_flush,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [31:0] cfg_data,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [4:0]       m_token_kind,
    output logic [31:0]      m_int_value,
    output logic [7:0]       m_token_length,
    output logic [31:0]      m_start_position,
    output logic [31:0]      m_src_line,
    output logic             m_last_of_run
);
    import csl_pkg::*;

    logic          q_push, q_pop, q_full, q_empty;
    entry_t        push_entry, head;
    token_t        out_tok;
    front_status_t front_status;

    assign cfg_ready = 1'b1;

    csl_front #(
        .MAX_TOKEN_LEN(MAX_TOKEN_LEN)
    ) u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_char_in  (s_char_in),
        .s_flush    (s_flush),
        .cfg_write  (cfg_valid && cfg_ready),
        .cfg_data   (cfg_data),
        .q_full     (q_full),
        .push       (q_push),
        .push_entry (push_entry),
        .status     (front_status)
    );

    csl_queue #(
        .DEPTH(QUEUE_DEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_entry (push_entry),
        .pop        (q_pop),
        .head       (head),
        .full       (q_full),
        .empty      (q_empty)
    );

    csl_back u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .head    (head),
        .q_empty (q_empty),
        .pop     (q_pop),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_token (out_tok),
        .m_last  (m_last_of_run)
    );

    assign m_token_kind     = 5'(out_tok.kind);
    assign m_int_value      = out_tok.value;
    assign m_token_length   = out_tok.length;
    assign m_start_position = out_tok.start;
    assign m_src_line       = out_tok.line;

    `CSL_ASSERT_NOW(a_no_push_when_full, q_push, !q_full)
    `CSL_ASSERT_NOW(a_no_pop_when_empty, q_pop, !q_empty)
    `CSL_ASSERT_NEXT(a_flush_clears_scan, s_valid && s_ready && s_flush,
        front_status.mode == MODE_IDLE && front_status.position == 32'd0)

endmodule

`default_nettype wire
